/* src/pee_pkg.sv */
package pee_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DIGIT_W     = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2b;
    localparam logic [7:0] CHAR_MINUS   = 8'h2d;
    localparam logic [7:0] CHAR_STAR    = 8'h2a;
    localparam logic [7:0] CHAR_SLASH   = 8'h2f;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_DIV0  = 3'd1,
        ST_UNDER = 3'd2,
        ST_OVER  = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_DIGIT,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_NEWLINE,
        OP_OTHER
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [DIGIT_W-1:0] digit;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_FETCH,
        BK_OPER,
        BK_DIVW
    } back_state_t;

endpackage

/* src/pee_ram.sv */
module pee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/pee_front.sv */
module pee_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             char_valid,
    output logic             char_stall,
    input  logic [7:0]       char_code,
    output logic             q_push,
    output pee_pkg::cmd_t    q_cmd,
    input  logic             q_full
);

    logic          front_valid_reg;
    logic          front_valid_next;
    pee_pkg::cmd_t cmd_reg;
    pee_pkg::cmd_t cmd_next;
    logic          accept;

    assign char_stall = front_valid_reg && q_full;
    assign accept     = char_valid && !char_stall;
    assign q_push     = front_valid_reg && !q_full;
    assign q_cmd      = cmd_reg;

    // classify the character
    always_comb
    begin
        logic [7:0] diff;
        diff           = char_code - pee_pkg::CHAR_ZERO;
        cmd_next.digit = diff[pee_pkg::DIGIT_W-1:0];
        if (char_code >= pee_pkg::CHAR_ZERO && char_code <= pee_pkg::CHAR_NINE)
        begin
            cmd_next.op = pee_pkg::OP_DIGIT;
        end
        else if (char_code == pee_pkg::CHAR_PLUS)
        begin
            cmd_next.op = pee_pkg::OP_ADD;
        end
        else if (char_code == pee_pkg::CHAR_MINUS)
        begin
            cmd_next.op = pee_pkg::OP_SUB;
        end
        else if (char_code == pee_pkg::CHAR_STAR)
        begin
            cmd_next.op = pee_pkg::OP_MUL;
        end
        else if (char_code == pee_pkg::CHAR_SLASH)
        begin
            cmd_next.op = pee_pkg::OP_DIV;
        end
        else if (char_code == pee_pkg::CHAR_NEWLINE)
        begin
            cmd_next.op = pee_pkg::OP_NEWLINE;
        end
        else
        begin
            cmd_next.op = pee_pkg::OP_OTHER;
        end
    end

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (accept)
        begin
            front_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

/* src/pee_queue.sv */
module pee_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pee_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output pee_pkg::cmd_t head_cmd
);

    pee_pkg::cmd_t                entry_reg [pee_pkg::QUEUE_DEPTH];
    logic [pee_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [pee_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [pee_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [pee_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [pee_pkg::QCNT_W-1:0]   cnt_reg;
    logic [pee_pkg::QCNT_W-1:0]   cnt_next;
    logic                         do_push;
    logic                         do_pop;

    assign full     = cnt_reg == pee_pkg::QCNT_W'(pee_pkg::QUEUE_DEPTH);
    assign valid    = cnt_reg != '0;
    assign head_cmd = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + pee_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + pee_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + pee_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - pee_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* src/pee_div.sv */
module pee_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pee_pkg::VALUE_WIDTH-1:0] dividend,
    input  logic [pee_pkg::VALUE_WIDTH-1:0] divisor,
    output logic                            done,
    output logic                            div_zero,
    output logic [pee_pkg::VALUE_WIDTH-1:0] quotient
);

    localparam int W     = pee_pkg::VALUE_WIDTH;
    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(W - 1);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     rem_next;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     quo_next;
    logic [W-1:0]     ub_reg;
    logic [W-1:0]     ub_next;
    logic             neg_reg;
    logic             neg_next;
    logic             zero_reg;
    logic             zero_next;

    always_comb
    begin
        logic [W:0]   rem_shift;
        logic [W:0]   diff;
        logic [W-1:0] ua;
        logic [W-1:0] ub;
        ua        = dividend[W-1] ? (-dividend) : dividend;
        ub        = divisor[W-1] ? (-divisor) : divisor;
        rem_shift = {rem_reg, quo_reg[W-1]};
        diff      = rem_shift - {1'b0, ub_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ub_next   = ub_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = ua;
            ub_next   = ub;
            neg_next  = dividend[W-1] ^ divisor[W-1];
            zero_next = ub == '0;
        end
        else if (busy_reg)
        begin
            // one restoring step per cycle
            rem_next = diff[W] ? rem_shift[W-1:0] : diff[W-1:0];
            quo_next = {quo_reg[W-2:0], !diff[W]};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        ub_reg   <= ub_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    assign done     = done_reg;
    assign div_zero = zero_reg;
    assign quotient = zero_reg ? '0 : (neg_reg ? (-quo_reg) : quo_reg);

endmodule

/* src/pee_back.sv */
module pee_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  pee_pkg::cmd_t                   q_cmd,
    output logic                            q_pop,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [pee_pkg::VALUE_WIDTH-1:0] result_value,
    output logic [2:0]                      status
);

    localparam int W  = pee_pkg::VALUE_WIDTH;
    localparam int CW = pee_pkg::COUNT_W;
    localparam int AW = pee_pkg::ADDR_W;

    pee_pkg::back_state_t state_reg;
    pee_pkg::back_state_t state_next;
    pee_pkg::op_t         op_reg;
    pee_pkg::op_t         op_next;
    pee_pkg::status_t     err_reg;
    pee_pkg::status_t     err_next;
    pee_pkg::status_t     out_status_reg;
    pee_pkg::status_t     out_status_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 innum_reg;
    logic                 innum_next;
    logic [W-1:0]         top_reg;
    logic [W-1:0]         top_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [W-1:0]         out_value_reg;
    logic [W-1:0]         out_value_next;
    logic                 out_load;
    logic                 out_free;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [AW-1:0]        ram_raddr;
    logic [W-1:0]         ram_rdata;

    logic                 div_start;
    logic                 div_done;
    logic                 div_zero;
    logic [W-1:0]         div_q;

    // entries below the top live in the RAM; the top sits in top_reg
    assign ram_waddr = AW'(count_reg - CW'(1));
    assign ram_raddr = AW'(count_reg - CW'(2));

    pee_ram #(
        .WIDTH (W),
        .DEPTH (pee_pkg::STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (top_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pee_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ram_rdata),
        .divisor  (top_reg),
        .done     (div_done),
        .div_zero (div_zero),
        .quotient (div_q)
    );

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        logic [W-1:0] prod;
        logic [W-1:0] dext;
        prod            = ram_rdata * top_reg;
        dext            = W'(q_cmd.digit);
        state_next      = state_reg;
        op_next         = op_reg;
        err_next        = err_reg;
        count_next      = count_reg;
        innum_next      = innum_reg;
        top_next        = top_reg;
        out_load        = 1'b0;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        div_start       = 1'b0;
        case (state_reg)
            pee_pkg::BK_FETCH:
            begin
                if (q_valid)
                begin
                    case (q_cmd.op)
                        pee_pkg::OP_DIGIT:
                        begin
                            q_pop = 1'b1;
                            if (innum_reg && count_reg != '0)
                            begin
                                top_next = (top_reg << 3) + (top_reg << 1) + dext;
                            end
                            else if (count_reg == CW'(pee_pkg::STACK_DEPTH))
                            begin
                                if (err_reg == pee_pkg::ST_OK)
                                begin
                                    err_next = pee_pkg::ST_OVER;
                                end
                            end
                            else
                            begin
                                ram_we     = count_reg != '0;
                                top_next   = dext;
                                count_next = count_reg + CW'(1);
                                innum_next = 1'b1;
                            end
                        end
                        pee_pkg::OP_ADD,
                        pee_pkg::OP_SUB,
                        pee_pkg::OP_MUL,
                        pee_pkg::OP_DIV:
                        begin
                            q_pop      = 1'b1;
                            innum_next = 1'b0;
                            if (count_reg < CW'(2))
                            begin
                                if (err_reg == pee_pkg::ST_OK)
                                begin
                                    err_next = pee_pkg::ST_UNDER;
                                end
                            end
                            else
                            begin
                                // go to BK_OPER for the registered RAM read of the lower operand
                                op_next    = q_cmd.op;
                                state_next = pee_pkg::BK_OPER;
                            end
                        end
                        pee_pkg::OP_NEWLINE:
                        begin
                            if (out_free)
                            begin
                                q_pop      = 1'b1;
                                out_load   = 1'b1;
                                innum_next = 1'b0;
                                count_next = '0;
                                err_next   = pee_pkg::ST_OK;
                                if (count_reg != '0)
                                begin
                                    out_value_next  = top_reg;
                                    out_status_next = err_reg;
                                end
                                else
                                begin
                                    out_value_next  = '0;
                                    out_status_next = (err_reg == pee_pkg::ST_OK) ?
                                                      pee_pkg::ST_EMPTY : err_reg;
                                end
                            end
                        end
                        default:
                        begin
                            q_pop      = 1'b1;
                            innum_next = 1'b0;
                        end
                    endcase
                end
            end
            pee_pkg::BK_OPER:
            begin
                state_next = pee_pkg::BK_FETCH;
                count_next = count_reg - CW'(1);
                case (op_reg)
                    pee_pkg::OP_ADD:
                    begin
                        top_next = ram_rdata + top_reg;
                    end
                    pee_pkg::OP_SUB:
                    begin
                        top_next = ram_rdata - top_reg;
                    end
                    pee_pkg::OP_MUL:
                    begin
                        top_next = prod;
                    end
                    default:
                    begin
                        div_start  = 1'b1;
                        count_next = count_reg;
                        state_next = pee_pkg::BK_DIVW;
                    end
                endcase
            end
            pee_pkg::BK_DIVW:
            begin
                if (div_done)
                begin
                    top_next   = div_q;
                    count_next = count_reg - CW'(1);
                    state_next = pee_pkg::BK_FETCH;
                    if (div_zero && err_reg == pee_pkg::ST_OK)
                    begin
                        err_next = pee_pkg::ST_DIV0;
                    end
                end
            end
            default:
            begin
                state_next = pee_pkg::BK_FETCH;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pee_pkg::BK_FETCH;
            err_reg       <= pee_pkg::ST_OK;
            count_reg     <= '0;
            innum_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            err_reg       <= err_next;
            count_reg     <= count_next;
            innum_reg     <= innum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        top_reg        <= top_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign result_valid = out_valid_reg;
    assign result_value = out_value_reg;
    assign status       = out_status_reg;

    a_oper_has_two : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != pee_pkg::BK_FETCH |-> count_reg >= CW'(2))
        else $error("binary operator running with fewer than two operands");

    a_div_start_src : assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> state_reg == pee_pkg::BK_OPER && op_reg == pee_pkg::OP_DIV)
        else $error("divider started outside a divide");

    a_div_done_wait : assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == pee_pkg::BK_DIVW)
        else $error("divider finished while nobody waits");

    a_newline_clears : assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> count_reg == '0 && err_reg == pee_pkg::ST_OK && out_valid_reg)
        else $error("end of expression did not clear the stack");

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> count_reg != CW'(pee_pkg::STACK_DEPTH) && count_reg != '0)
        else $error("stack write outside the stored range");

endmodule

/* src/postfix_expression_evaluator_unit.sv */
// Postfix integer expression evaluator.
// Input channel: char_valid / char_stall / char_code, one ASCII character per
// request. Digits build a value, + - * / work on the operand stack (16 deep,
// 32-bit two's complement, division truncates toward zero), a newline ends
// the expression; every other character only ends a number.
// Output channel: result_valid / result_stall / result_value / status, one
// request per newline: the top of stack (0 if empty) and the first error seen
// (0 ok, 1 divide by zero, 2 underflow, 3 overflow, 4 empty stack).
// With the queue empty and the execution side idle, a taken newline passes
// the input register, the queue and the output register before result_valid
// rises. Digits, spaces, newlines and other characters are handled in BK_FETCH;
// + - * / also pass BK_OPER for the registered stack RAM read of the lower
// operand, and / then waits in BK_DIVW for the one-bit-per-cycle divider.
// A two-entry command queue sits between the input register and the
// execution side, so input keeps flowing during short operations.
// Reset (rst_n, asynchronous, low) empties the stack, queue and output
// register and clears the error status; the stack RAM itself is not cleared.
// When the receiver stalls, the result is held; execution goes on until the
// next newline, which waits for the output register, and the queue then
// fills and stalls the input.
module postfix_expression_evaluator_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            char_valid,
    output logic                            char_stall,
    input  logic [7:0]                      char_code,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [pee_pkg::VALUE_WIDTH-1:0] result_value,
    output logic [2:0]                      status
);

    // front to queue
    logic          f_push;
    pee_pkg::cmd_t f_cmd;
    logic          q_full;

    // queue to back
    logic          q_valid;
    logic          q_pop;
    pee_pkg::cmd_t q_cmd;

    // front: input register and character classification
    pee_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_code  (char_code),
        .q_push     (f_push),
        .q_cmd      (f_cmd),
        .q_full     (q_full)
    );

    // decoupling queue of classified commands
    pee_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_push),
        .push_cmd (f_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_cmd (q_cmd)
    );

    // back: stack, arithmetic, divider and output register
    pee_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_value (result_value),
        .status       (status)
    );

endmodule
